FILE: rtl/core/lfs_pkg.sv
// ----------------------------------------------------------------------------
// lfs_pkg
// shared types, sizes and helpers for the streaming life automaton
// ----------------------------------------------------------------------------
package lfs_pkg;

	// largest grid, border ring included
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// register field width and position counter widths
	localparam int SIZE_W = 11;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);

	typedef logic [SIZE_W-1:0] grid_size_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ROW_W-1:0]  row_t;

	localparam grid_size_t MIN_SIZE   = grid_size_t'(3);
	localparam grid_size_t MAX_WIDTH_SZ  = grid_size_t'(MAX_WIDTH);
	localparam grid_size_t MAX_HEIGHT_SZ = grid_size_t'(MAX_HEIGHT);

	// configuration register indexes
	typedef enum logic {
		CFG_GRID_WIDTH  = 1'b0,
		CFG_GRID_HEIGHT = 1'b1
	} cfg_index_t;

	// result codes
	localparam logic [1:0] NS_DEAD     = 2'd0;
	localparam logic [1:0] NS_SURVIVED = 2'd1;
	localparam logic [1:0] NS_BORN     = 2'd2;

	// line store entry: bit for the row two above and the row just above
	localparam int LINE_UPPER  = 0;
	localparam int LINE_MIDDLE = 1;
	typedef logic [1:0] line_entry_t;

	// position flags of an incoming cell
	typedef struct packed {
		logic spark_ok;  // interior cell, spark may force it alive
		logic produce;   // a result is due for the cell up and left
		logic last;      // that result is the last interior cell
	} pos_flags_t;

	// line store write request
	typedef struct packed {
		logic        en;
		col_t        addr;
		line_entry_t data;
	} line_wr_t;

	function automatic grid_size_t clamp_size(input grid_size_t v, input grid_size_t hi);
		grid_size_t r;
		r = v;
		if (v < MIN_SIZE) begin
			r = MIN_SIZE;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/lfs_if.sv
// ----------------------------------------------------------------------------
// lfs channel interfaces
// valid/ready channels for incoming cells and outgoing results
// ----------------------------------------------------------------------------
interface lfs_cell_if;
	logic valid;
	logic ready;
	logic cell_alive;
	logic spark;

	modport source (output valid, output cell_alive, output spark, input ready);
	modport sink (input valid, input cell_alive, input spark, output ready);
endinterface

interface lfs_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] next_state;
	logic       last_cell;

	modport source (output valid, output next_state, output last_cell, input ready);
	modport sink (input valid, input next_state, input last_cell, output ready);
endinterface

FILE: rtl/core/lfs_pos_ctrl.sv
// ----------------------------------------------------------------------------
// lfs_pos_ctrl
// grid size registers and raster position counters
// ----------------------------------------------------------------------------
module lfs_pos_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  lfs_pkg::cfg_index_t  cfg_index,
	input  lfs_pkg::grid_size_t  cfg_wdata,
	input  logic                 step,
	output lfs_pkg::col_t        col_addr,
	output lfs_pkg::pos_flags_t  flags
);
	import lfs_pkg::*;

	grid_size_t width_q;
	grid_size_t height_q;
	col_t       col_q;
	row_t       row_q;
	grid_size_t w;
	grid_size_t h;
	grid_size_t c_ext;
	grid_size_t r_ext;
	logic       row_end;
	logic       frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= MAX_WIDTH_SZ;
			height_q <= MAX_HEIGHT_SZ;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_GRID_WIDTH:  width_q  <= cfg_wdata;
				CFG_GRID_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		w         = clamp_size(width_q, MAX_WIDTH_SZ);
		h         = clamp_size(height_q, MAX_HEIGHT_SZ);
		c_ext     = grid_size_t'(col_q);
		r_ext     = grid_size_t'(row_q);
		row_end   = (c_ext + grid_size_t'(1)) >= w;
		frame_end = (r_ext + grid_size_t'(1)) >= h;

		flags.spark_ok = (row_q != '0) && ((r_ext + grid_size_t'(2)) <= h)
			&& (col_q != '0) && ((c_ext + grid_size_t'(2)) <= w);
		flags.produce  = (r_ext >= grid_size_t'(2)) && ((r_ext + grid_size_t'(1)) <= h)
			&& (c_ext >= grid_size_t'(2)) && ((c_ext + grid_size_t'(1)) <= w);
		flags.last     = ((r_ext + grid_size_t'(1)) == h) && ((c_ext + grid_size_t'(1)) == w);
	end

	assign col_addr = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + row_t'(1);
			end else begin
				col_q <= col_q + col_t'(1);
			end
		end
	end

endmodule

FILE: rtl/core/lfs_line_store.sv
// ----------------------------------------------------------------------------
// lfs_line_store
// two row buffers held as one memory, registered read
// ----------------------------------------------------------------------------
module lfs_line_store (
	input  logic                 clk,
	input  logic                 rd_en,
	input  lfs_pkg::col_t        rd_addr,
	output lfs_pkg::line_entry_t rd_data,
	input  lfs_pkg::line_wr_t    wr
);
	import lfs_pkg::*;

	line_entry_t mem [MAX_WIDTH];
	line_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/lfs_window_eval.sv
// ----------------------------------------------------------------------------
// lfs_window_eval
// cell stage, neighbour window, b3/s23 rule and result register
// ----------------------------------------------------------------------------
module lfs_window_eval (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic                 cell_alive,
	input  logic                 spark,
	input  lfs_pkg::pos_flags_t  flags,
	input  lfs_pkg::col_t        col_addr,
	input  lfs_pkg::line_entry_t line_rd,
	output lfs_pkg::line_wr_t    line_wr,
	output logic                 in_ready,
	lfs_result_if.source         results
);
	import lfs_pkg::*;

	logic       valid_s1;
	logic       cur_s1;
	pos_flags_t flags_s1;
	col_t       col_s1;
	logic [5:0] window_q;
	logic       out_valid_q;
	logic [1:0] next_state_q;
	logic       last_cell_q;
	logic       advance;
	logic [2:0] col_bits;
	logic [3:0] count;
	logic [1:0] ns;

	// the stage moves on whenever the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || results.ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		col_bits = {cur_s1, line_rd[LINE_MIDDLE], line_rd[LINE_UPPER]};
		count    = 4'(window_q[0]) + 4'(window_q[2]) + 4'(window_q[3])
			+ 4'(window_q[4]) + 4'(window_q[5])
			+ 4'(col_bits[0]) + 4'(col_bits[1]) + 4'(col_bits[2]);
		if (window_q[1]) begin
			ns = ((count == 4'd2) || (count == 4'd3)) ? NS_SURVIVED : NS_DEAD;
		end else begin
			ns = (count == 4'd3) ? NS_BORN : NS_DEAD;
		end
	end

	// middle row moves up, incoming cell becomes the new middle row
	always_comb begin
		line_wr.en                = advance;
		line_wr.addr              = col_s1;
		line_wr.data[LINE_UPPER]  = line_rd[LINE_MIDDLE];
		line_wr.data[LINE_MIDDLE] = cur_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cur_s1   <= cell_alive | (spark & flags.spark_ok);
			flags_s1 <= flags;
			col_s1   <= col_addr;
		end
	end

	// advance only happens with the result register empty or being emptied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				window_q    <= {window_q[2:0], col_bits};
				out_valid_q <= flags_s1.produce;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && flags_s1.produce) begin
			next_state_q <= ns;
			last_cell_q  <= flags_s1.last;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.next_state = next_state_q;
	assign results.last_cell  = last_cell_q;

endmodule

FILE: rtl/core/life_automaton_stream_top.sv
// ----------------------------------------------------------------------------
// life_automaton_stream_top
// streaming b3/s23 life step over a framed grid, one cell per item
// ----------------------------------------------------------------------------
// a result is registered in the result register as the item that completes its window leaves the cell stage
// throughput: one item per cycle unless a waiting result is stalled, one result per interior cell, none on the border
// the rate is set by one line store read and one line store write per item
// reset: position counters and window cleared, grid size back to 1024 x 1024
// the line stores are not cleared; the first two rows of a frame fill them
module life_automaton_stream_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  lfs_pkg::cfg_index_t cfg_index,
	input  lfs_pkg::grid_size_t cfg_wdata,
	lfs_cell_if.sink            cells,
	lfs_result_if.source        results
);
	import lfs_pkg::*;

	logic        in_ready;
	logic        in_fire;
	col_t        col_addr;
	pos_flags_t  flags;
	line_entry_t line_rd;
	line_wr_t    line_wr;

	// an item is taken when the cell stage is empty or moving on
	assign cells.ready = in_ready;
	assign in_fire     = cells.valid && in_ready;

	// grid size registers and raster position of the next incoming cell
	lfs_pos_ctrl u_pos_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.step      (in_fire),
		.col_addr  (col_addr),
		.flags     (flags)
	);

	// the two rows above, read as the cell is taken, written as it moves on
	lfs_line_store u_line_store (
		.clk     (clk),
		.rd_en   (in_fire),
		.rd_addr (col_addr),
		.rd_data (line_rd),
		.wr      (line_wr)
	);

	// 3x3 window, neighbour count, rule and result register
	lfs_window_eval u_window_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.cell_alive (cells.cell_alive),
		.spark      (cells.spark),
		.flags      (flags),
		.col_addr   (col_addr),
		.line_rd    (line_rd),
		.line_wr    (line_wr),
		.in_ready   (in_ready),
		.results    (results)
	);

endmodule

FILE: bench/life_automaton_stream_top_test.sv
// ----------------------------------------------------------------------------
// life_automaton_stream_top_test
// self-checking bench for the streaming b3/s23 life step: whole frames are
// fed in raster order, each result is checked against a bit-level predictor
// kept alongside the block, with grid sizes, idle patterns and stalls varied
// ----------------------------------------------------------------------------
module life_automaton_stream_top_test;
	import lfs_pkg::*;

	// idling patterns of the two channels
	typedef enum int {
		FLOW_FREE,
		SENDER_SLOW,
		RECEIVER_SLOW,
		BOTH_SLOW
	} flow_mode_t;

	// one result item as the block gives it
	typedef struct packed {
		logic [1:0] next_state;
		logic       last_cell;
	} cell_fate_t;

	// a 3x3 frame typed in by hand: bit 8 is the top-left cell, rows read left to right
	typedef struct packed {
		logic [8:0] cells;
		logic [8:0] sparks;
		logic [1:0] fate;
	} tiny_frame_t;

	localparam int RANDOM_CELLS      = 1000;
	localparam int RESET_PROBE_CELLS = 40;
	localparam int SPARK_PCT         = 6;
	localparam int RIM_LIVE_PCT      = 8;
	localparam int DRAIN_CYCLES      = 8;
	localparam int WATCHDOG_LIMIT    = 2000;

	// birth on three with a spark on the rim that must be ignored,
	// survival on two with the centre forced alive by a spark,
	// death of a crowded centre with four corners alive
	localparam tiny_frame_t TINY_FRAMES [3] = '{
		{9'b100_000_011, 9'b000_000_100, NS_BORN},
		{9'b010_000_010, 9'b000_010_000, NS_SURVIVED},
		{9'b101_010_101, 9'b000_000_000, NS_DEAD}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	cfg_index_t cfg_index;
	grid_size_t cfg_wdata;

	lfs_cell_if   cells_ch ();
	lfs_result_if results_ch ();

	life_automaton_stream_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cells     (cells_ch),
		.results   (results_ch)
	);

	// predictor copy of the block: registers, line stores, window and position
	grid_size_t width_reg  = MAX_WIDTH_SZ;
	grid_size_t height_reg = MAX_HEIGHT_SZ;
	bit         upper_cells  [MAX_WIDTH];
	bit         middle_cells [MAX_WIDTH];
	logic [5:0] window_cols = '0;
	col_t       col_pos = '0;
	row_t       row_pos = '0;

	// results predicted but not yet seen, oldest first
	cell_fate_t pending_fates [$];

	int sender_idle_pct   = 0;
	int receiver_stall_pct = 0;
	int error_count   = 0;
	int cells_sent    = 0;
	int results_seen  = 0;
	int frames_done   = 0;

	// 10 time unit clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		error_count++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	// size register as the block reads it
	function automatic int fit_size(input grid_size_t v, input int hi);
		if (v < MIN_SIZE) return int'(MIN_SIZE);
		if (int'(v) > hi) return hi;
		return int'(v);
	endfunction

	// one accepted cell through the predictor; returns 1 when a result is due
	function automatic bit life_step(input bit alive, input bit spark, output cell_fate_t fate);
		int         w;
		int         h;
		int         c;
		int         r;
		int         live_count;
		bit         cur;
		bit         up;
		bit         mid;
		bit         due;
		logic [2:0] column;
		w = fit_size(width_reg, MAX_WIDTH);
		h = fit_size(height_reg, MAX_HEIGHT);
		c = int'(col_pos);
		r = int'(row_pos);
		fate = '0;
		cur = alive;
		// spark counts only inside the border ring
		if (spark && r >= 1 && r + 2 <= h && c >= 1 && c + 2 <= w) cur = 1'b1;
		up  = upper_cells[c];
		mid = middle_cells[c];
		upper_cells[c]  = mid;
		middle_cells[c] = cur;
		column = {cur, mid, up};
		// the window now completes the neighbourhood of the cell up and left
		due = r >= 2 && r + 1 <= h && c >= 2 && c + 1 <= w;
		if (due) begin
			live_count = $countones({window_cols[5:2], window_cols[0], column});
			if (window_cols[1]) begin
				fate.next_state = (live_count == 2 || live_count == 3) ? NS_SURVIVED : NS_DEAD;
			end else begin
				fate.next_state = (live_count == 3) ? NS_BORN : NS_DEAD;
			end
			fate.last_cell = (r + 1 == h && c + 1 == w);
		end
		window_cols = {window_cols[2:0], column};
		if (c + 1 >= w) begin
			col_pos = '0;
			row_pos = (r + 1 >= h) ? row_t'(0) : row_t'(r + 1);
		end else begin
			col_pos = col_t'(c + 1);
		end
		return due;
	endfunction

	task automatic set_flow(input flow_mode_t mode);
		sender_idle_pct    = (mode == SENDER_SLOW) ? 81 : (mode == BOTH_SLOW) ? 10 : 0;
		receiver_stall_pct = (mode == RECEIVER_SLOW) ? 81 : (mode == BOTH_SLOW) ? 10 : 0;
	endtask

	// register write, only ever issued with the block idle
	task automatic write_reg(input cfg_index_t idx, input int value);
		grid_size_t v;
		v = grid_size_t'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_GRID_WIDTH) width_reg = v;
		else height_reg = v;
	endtask

	// one cell item; valid is left high so back-to-back items need no gap
	task automatic send_cell(input bit alive, input bit spark, input bit typed,
			input cell_fate_t typed_fate);
		cell_fate_t fate;
		while ($urandom_range(99) < sender_idle_pct) begin
			cells_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cells_ch.valid      <= 1'b1;
		cells_ch.cell_alive <= alive;
		cells_ch.spark      <= spark;
		do @(posedge clk); while (cells_ch.ready !== 1'b1);
		cells_sent++;
		if (life_step(alive, spark, fate)) pending_fates.push_back(typed ? typed_fate : fate);
	endtask

	// random cell for the current position: rim mostly dead, interior at the given density
	task automatic feed_cell(input int density);
		int w;
		int h;
		bit on_rim;
		bit alive;
		w = fit_size(width_reg, MAX_WIDTH);
		h = fit_size(height_reg, MAX_HEIGHT);
		on_rim = row_pos == 0 || col_pos == 0 || int'(row_pos) + 1 >= h || int'(col_pos) + 1 >= w;
		alive = on_rim ? ($urandom_range(99) < RIM_LIVE_PCT) : ($urandom_range(99) < density);
		send_cell(alive, $urandom_range(99) < SPARK_PCT, 1'b0, '0);
	endtask

	// stop sending, let every expected result out, then give the pipeline time to empty
	task automatic settle_block();
		cells_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_fates.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// cells until the position is back at the frame origin, optionally holding off midway
	task automatic run_frame(input int density, input bit hold_midway);
		int pause_at;
		int k;
		pause_at = -1;
		if (hold_midway) begin
			pause_at = $urandom_range(fit_size(width_reg, MAX_WIDTH)
				* fit_size(height_reg, MAX_HEIGHT) - 1);
		end
		k = 0;
		do begin
			if (k == pause_at) settle_block();
			feed_cell(density);
			k++;
		end while (col_pos != 0 || row_pos != 0);
		frames_done++;
	endtask

	// result side: check each accepted result, then choose ready for the next edge
	always @(posedge clk) begin : result_check
		cell_fate_t want;
		if (arst_n === 1'b1 && results_ch.valid === 1'b1 && results_ch.ready === 1'b1) begin
			results_seen++;
			if (pending_fates.size() == 0) begin
				flag_error($sformatf("result %0d/%0d with nothing expected",
					results_ch.next_state, results_ch.last_cell));
			end else begin
				want = pending_fates.pop_front();
				if (results_ch.next_state !== want.next_state)
					flag_error($sformatf("next_state %0d, expected %0d",
						results_ch.next_state, want.next_state));
				if (results_ch.last_cell !== want.last_cell)
					flag_error($sformatf("last_cell %0d, expected %0d",
						results_ch.last_cell, want.last_cell));
			end
		end
		results_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// watchdog: too long with neither channel moving ends the run
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cells_ch.valid === 1'b1 && cells_ch.ready === 1'b1)
					|| (results_ch.valid === 1'b1 && results_ch.ready === 1'b1)) quiet = 0;
			else quiet++;
		end
		$display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		int random_start;
		// every input known from time zero, ready comes from the result side
		arst_n              <= 1'b0;
		cfg_wr_en           <= 1'b0;
		cfg_index           <= CFG_GRID_WIDTH;
		cfg_wdata           <= '0;
		cells_ch.valid      <= 1'b0;
		cells_ch.cell_alive <= 1'b0;
		cells_ch.spark      <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size is 1024 x 1024: the start of the first row wraps nowhere
		// and gives no result
		set_flow(FLOW_FREE);
		repeat (RESET_PROBE_CELLS) feed_cell(40);
		settle_block();
		// shrink mid-frame: the position wraps back to the origin within a few items
		write_reg(CFG_GRID_WIDTH, 3);
		write_reg(CFG_GRID_HEIGHT, 3);
		run_frame(40, 1'b0);

		// hand-worked 3x3 frames, one result each and always the last cell
		for (int f = 0; f < 3; f++) begin
			for (int i = 8; i >= 0; i--) begin
				send_cell(TINY_FRAMES[f].cells[i], TINY_FRAMES[f].sparks[i], 1'b1,
					{TINY_FRAMES[f].fate, 1'b1});
			end
			frames_done++;
		end

		// sizes below the minimum clamp: width 2 and height 0 make a 3x3 frame
		settle_block();
		write_reg(CFG_GRID_WIDTH, 2);
		write_reg(CFG_GRID_HEIGHT, 0);
		run_frame(45, 1'b1);
		// sizes above the maximum clamp: all-ones width and height just over the
		// maximum, part of a first row, then a mid-frame shrink to close the frame
		settle_block();
		write_reg(CFG_GRID_WIDTH, 2047);
		write_reg(CFG_GRID_HEIGHT, MAX_HEIGHT + 1);
		repeat (RESET_PROBE_CELLS) feed_cell(45);
		settle_block();
		write_reg(CFG_GRID_WIDTH, 4);
		write_reg(CFG_GRID_HEIGHT, 4);
		run_frame(45, 1'b0);

		// random small frames, cycling through the idle patterns
		random_start = cells_sent;
		while (cells_sent - random_start < RANDOM_CELLS) begin
			settle_block();
			case ($urandom_range(7))
				0: begin
					write_reg(CFG_GRID_WIDTH, $urandom_range(2));
					write_reg(CFG_GRID_HEIGHT, $urandom_range(3, 10));
				end
				1: write_reg(CFG_GRID_HEIGHT, $urandom_range(0, 10));
				2: write_reg(CFG_GRID_WIDTH, $urandom_range(3, 12));
				default: begin
					write_reg(CFG_GRID_WIDTH, $urandom_range(3, 12));
					write_reg(CFG_GRID_HEIGHT, $urandom_range(3, 10));
				end
			endcase
			set_flow(flow_mode_t'(frames_done % 4));
			run_frame($urandom_range(15, 60), $urandom_range(2) == 0);
		end

		// let the last results out, plus a margin for any stray one
		settle_block();
		$display("covered %0d cells in %0d frames, %0d results compared", cells_sent,
			frames_done, results_seen);
		$display("grids of 3 to 12 per side, clamped and mid-frame sizes, all idle patterns");
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
